@@ rtl/core/bbe_pkg.sv @@
// Shared types, constants and the reciprocal table of the 3x3 box blur.
`default_nettype none

package bbe_pkg;

    localparam int CH_W           = 8;
    localparam int PIX_W          = 3 * CH_W;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd768;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } req_t;

    localparam int TAPS    = 9;
    localparam int SUM_W   = 12;
    localparam int CNT_W   = 4;
    localparam int NUM_W   = 13;
    localparam int RECIP_K = 20;
    localparam int RECIP_W = 20;
    localparam int PROD_W  = NUM_W + RECIP_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic            emit;
        logic            frame_end;
        logic [TAPS-1:0] mask;
    } bbe_ctrl_t;

    // ceil(2^20 / (2*count)); exact floor division for every numerator this block sees.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        unique case (cnt)
            4'd1:    r = 20'd524288;
            4'd2:    r = 20'd262144;
            4'd3:    r = 20'd174763;
            4'd4:    r = 20'd131072;
            4'd5:    r = 20'd104858;
            4'd6:    r = 20'd87382;
            4'd7:    r = 20'd74899;
            4'd8:    r = 20'd65536;
            4'd9:    r = 20'd58255;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/bbe_queue.sv @@
// Short FIFO between the classifying front end and the blur back end.
`default_nettype none

module bbe_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      pop_data,
    output logic                   valid
);
    import bbe_pkg::*;

    logic [DATA_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count above depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("front end pushed into a full queue");

    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !full && !do_pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("queue fill count did not follow a push");

endmodule

`default_nettype wire

@@ rtl/core/bbe_front.sv @@
// Front end: configuration, request checks, position counters and tap masks.
`default_nettype none

module bbe_front #(
    parameter  int MAX_WIDTH  = 1024,
    parameter  int MAX_HEIGHT = 4096,
    localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [bbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bbe_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_req_type,
    input  wire logic [bbe_pkg::CH_W-1:0]         s_in_red,
    input  wire logic [bbe_pkg::CH_W-1:0]         s_in_green,
    input  wire logic [bbe_pkg::CH_W-1:0]         s_in_blue,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output bbe_pkg::bbe_ctrl_t                    q_ctrl,
    output logic [COL_W-1:0]                      q_col,
    output logic [bbe_pkg::PIX_W-1:0]             q_pix
);
    import bbe_pkg::*;

    localparam int EW  = $clog2(MAX_WIDTH + 1);
    localparam int EH  = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = EH + 2;
    localparam int CXW = EW + 1;
    localparam int RXW = RW + 1;

    logic [FRAME_WIDTH_W-1:0]  fw_reg;
    logic [FRAME_HEIGHT_W-1:0] fh_reg;
    logic [EW-1:0]             eff_w;
    logic [EH-1:0]             eff_h;

    logic [COL_W-1:0] icol_reg, icol_next, ocol_reg, ocol_next;
    logic [RW-1:0]    irow_reg, irow_next, orow_reg, orow_next;

    logic [CXW-1:0] w_x, icol_inc, ocol_inc;
    logic [RXW-1:0] h_x, irow_x, orow_x;
    logic           draining, ignore, live, due, frame_end;
    logic [2:0]     rv, cv;
    logic [TAPS-1:0] mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= FRAME_WIDTH_RST;
            fh_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  fw_reg <= cfg_wr_data[FRAME_WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: fh_reg <= cfg_wr_data[FRAME_HEIGHT_W-1:0];
            endcase
        end
    end

    // Zero acts as one and values above the maximum are clamped.
    always_comb begin
        if (fw_reg == '0) begin
            eff_w = EW'(1);
        end else if (32'(fw_reg) > 32'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(fw_reg);
        end
        if (fh_reg == '0) begin
            eff_h = EH'(1);
        end else if (32'(fh_reg) > 32'(MAX_HEIGHT)) begin
            eff_h = EH'(MAX_HEIGHT);
        end else begin
            eff_h = EH'(fh_reg);
        end
    end

    assign w_x      = CXW'(eff_w);
    assign h_x      = RXW'(eff_h);
    assign icol_inc = CXW'(icol_reg) + CXW'(1);
    assign ocol_inc = CXW'(ocol_reg) + CXW'(1);
    assign irow_x   = RXW'(irow_reg);
    assign orow_x   = RXW'(orow_reg);

    assign draining = (irow_x >= h_x);
    assign ignore   = (s_req_type == REQ_DRAIN) ? !draining : draining;
    assign s_ready  = !q_full;
    assign live     = s_valid && s_ready && !ignore;
    assign due      = (irow_x >= RXW'(2)) || ((irow_x == RXW'(1)) && (icol_reg != '0));

    // The window is viewed after the new column is shifted in. On the first
    // column of a row the right-hand column belongs to the next row and is dropped.
    assign rv[0] = (orow_reg != '0) && (orow_x <= h_x);
    assign rv[1] = (orow_x < h_x);
    assign rv[2] = ((orow_x + RXW'(1)) < h_x);
    assign cv[0] = (ocol_reg != '0) && (CXW'(ocol_reg) <= w_x);
    assign cv[1] = (CXW'(ocol_reg) < w_x);
    assign cv[2] = (icol_reg != '0) && (ocol_inc < w_x);

    always_comb begin
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                mask[dr*3 + dc] = rv[dr] && cv[dc];
            end
        end
    end

    assign frame_end = ((orow_x + RXW'(1)) >= h_x) && (ocol_inc >= w_x);

    always_comb begin
        icol_next = icol_reg;
        irow_next = irow_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        if (live) begin
            if (due && frame_end) begin
                icol_next = '0;
                irow_next = '0;
                ocol_next = '0;
                orow_next = '0;
            end else begin
                if (due) begin
                    if (ocol_inc >= w_x) begin
                        ocol_next = '0;
                        orow_next = orow_reg + RW'(1);
                    end else begin
                        ocol_next = COL_W'(ocol_inc);
                    end
                end
                if (icol_inc >= w_x) begin
                    icol_next = '0;
                    irow_next = irow_reg + RW'(1);
                end else begin
                    icol_next = COL_W'(icol_inc);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            icol_reg <= '0;
            irow_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
        end else begin
            icol_reg <= icol_next;
            irow_reg <= irow_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
        end
    end

    assign q_push = live;
    assign q_col  = icol_reg;
    assign q_pix  = (s_req_type == REQ_DRAIN) ? '0 : {s_in_red, s_in_green, s_in_blue};

    always_comb begin
        q_ctrl           = '0;
        q_ctrl.emit      = due;
        q_ctrl.frame_end = frame_end;
        q_ctrl.mask      = mask;
    end

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (live && due && frame_end) |=> (icol_reg == '0 && orow_reg == '0))
        else $error("counters not cleared after the last pixel of a frame");

endmodule

`default_nettype wire

@@ rtl/core/bbe_back.sv @@
// Back end: line stores, 3x3 window, masked sums and the rounding divide.
`default_nettype none

module bbe_back #(
    parameter  int MAX_WIDTH = 1024,
    localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      q_valid,
    output logic                           q_pop,
    input  wire bbe_pkg::bbe_ctrl_t        q_ctrl,
    input  wire logic [COL_W-1:0]          q_col,
    input  wire logic [bbe_pkg::PIX_W-1:0] q_pix,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [bbe_pkg::CH_W-1:0]       m_out_red,
    output logic [bbe_pkg::CH_W-1:0]       m_out_green,
    output logic [bbe_pkg::CH_W-1:0]       m_out_blue,
    output logic                           m_frame_end
);
    import bbe_pkg::*;

    logic [PIX_W-1:0] older_mem [MAX_WIDTH];
    logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_older_reg, rd_newer_reg, last_new_reg;

    logic [PIX_W-1:0] win_reg [TAPS];

    logic             adv;
    logic             a_valid_reg, a_fwd_reg;
    bbe_ctrl_t        a_ctrl_reg;
    logic [PIX_W-1:0] a_pix_reg;
    logic [COL_W-1:0] a_col_reg;
    logic [PIX_W-1:0] old_v, new_v;
    logic             a_done;

    logic            b_valid_reg, b_fe_reg;
    logic [TAPS-1:0] b_mask_reg;
    logic [SUM_W-1:0] sum [3];
    logic [CNT_W-1:0] cnt;

    logic               c_valid_reg, c_fe_reg;
    logic [NUM_W-1:0]   c_num_reg [3];
    logic [RECIP_W-1:0] c_recip_reg;

    logic              out_valid_reg, out_fe_reg;
    logic [PROD_W-1:0] out_prod_reg [3];

    // The whole pipeline moves as one; it halts only while a result waits.
    assign adv    = !out_valid_reg || m_ready;
    assign q_pop  = q_valid && adv;
    assign a_done = a_valid_reg && adv;

    // An item at the same column right behind its predecessor would read the
    // older store before the predecessor's write lands, so that word is forwarded.
    assign old_v = a_fwd_reg ? last_new_reg : rd_older_reg;
    assign new_v = rd_newer_reg;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rd_older_reg <= older_mem[q_col];
        end
        if (a_done) begin
            older_mem[a_col_reg] <= new_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rd_newer_reg     <= newer_mem[q_col];
            newer_mem[q_col] <= q_pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < TAPS; k++) begin
                win_reg[k] <= '0;
            end
        end else if (a_done) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r*3]     <= win_reg[r*3 + 1];
                win_reg[r*3 + 1] <= win_reg[r*3 + 2];
            end
            win_reg[2] <= old_v;
            win_reg[5] <= new_v;
            win_reg[8] <= a_pix_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = '0;
            for (int j = 0; j < TAPS; j++) begin
                if (b_mask_reg[j]) begin
                    sum[k] = sum[k] + SUM_W'(win_reg[j][PIX_W-1-k*CH_W -: CH_W]);
                end
            end
        end
        cnt = CNT_W'($countones(b_mask_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            a_fwd_reg     <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg   <= q_pop;
            a_fwd_reg     <= q_pop && a_valid_reg && (a_col_reg == q_col);
            b_valid_reg   <= a_valid_reg && a_ctrl_reg.emit;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_done) begin
            last_new_reg <= new_v;
        end
        if (adv) begin
            if (q_pop) begin
                a_ctrl_reg <= q_ctrl;
                a_pix_reg  <= q_pix;
                a_col_reg  <= q_col;
            end
            b_fe_reg    <= a_ctrl_reg.frame_end;
            b_mask_reg  <= a_ctrl_reg.mask;
            c_fe_reg    <= b_fe_reg;
            c_recip_reg <= recip(cnt);
            out_fe_reg  <= c_fe_reg;
            for (int k = 0; k < 3; k++) begin
                // Rounded half up: (2*sum + count) / (2*count).
                c_num_reg[k]    <= NUM_W'({sum[k], 1'b0}) + NUM_W'(cnt);
                out_prod_reg[k] <= PROD_W'(c_num_reg[k]) * PROD_W'(c_recip_reg);
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_frame_end = out_fe_reg;
    assign m_out_red   = out_prod_reg[0][RECIP_K +: CH_W];
    assign m_out_green = out_prod_reg[1][RECIP_K +: CH_W];
    assign m_out_blue  = out_prod_reg[2][RECIP_K +: CH_W];

    a_fwd_live: assert property (@(posedge aclk) disable iff (!aresetn)
        a_fwd_reg |-> a_valid_reg)
        else $error("older-row forward flagged without an item in the read stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !adv) |=> (a_valid_reg && $stable(a_col_reg)))
        else $error("read stage moved while the pipeline was halted");

endmodule

`default_nettype wire

@@ rtl/core/box_blur_3x3_edge_aware_unit.sv @@
// Top level of the streaming 3x3 edge-aware box blur.
//
// Streaming 3x3 box blur on RGB pixels in raster order. Each result pixel is
// the per-channel mean of its neighbors inside the frame, rounded half up,
// and results trail the input by frame_width+1 accepted items; after the last
// pixel the source sends frame_width+1 drain ticks to flush the tail, and
// frame_end marks the last result of the frame. The block sustains one item
// per clock while no result waits on m_ready: the front end checks each item
// and advances the position counters in the cycle it is accepted, a four-entry
// queue decouples it from the back end, and the back end does the
// read-modify-write of the two line stores for each item (MAX_WIDTH words of
// 24 bits each, one read and one write port per store). The whole back end
// halts while a result waits on m_ready, and input is refused only once the
// queue is full. Pixels that arrive while a frame drains and drain ticks sent
// too early are accepted and dropped. The user must write width and height
// through the cfg port only while the block is idle; the block does not
// enforce this. Zero acts as one and values above MAX_WIDTH or MAX_HEIGHT clamp.
`default_nettype none

module box_blur_3x3_edge_aware_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [bbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bbe_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_req_type,
    input  wire logic [bbe_pkg::CH_W-1:0]       s_in_red,
    input  wire logic [bbe_pkg::CH_W-1:0]       s_in_green,
    input  wire logic [bbe_pkg::CH_W-1:0]       s_in_blue,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [bbe_pkg::CH_W-1:0]            m_out_red,
    output logic [bbe_pkg::CH_W-1:0]            m_out_green,
    output logic [bbe_pkg::CH_W-1:0]            m_out_blue,
    output logic                                m_frame_end
);
    import bbe_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int Q_W   = $bits(bbe_ctrl_t) + COL_W + PIX_W;

    logic             f_push, q_full, q_valid, q_pop;
    bbe_ctrl_t        f_ctrl, b_ctrl;
    logic [COL_W-1:0] f_col, b_col;
    logic [PIX_W-1:0] f_pix, b_pix;
    logic [Q_W-1:0]   push_data, pop_data;

    bbe_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_in_red    (s_in_red),
        .s_in_green  (s_in_green),
        .s_in_blue   (s_in_blue),
        .q_full      (q_full),
        .q_push      (f_push),
        .q_ctrl      (f_ctrl),
        .q_col       (f_col),
        .q_pix       (f_pix)
    );

    assign push_data = {f_ctrl, f_col, f_pix};

    bbe_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .valid     (q_valid)
    );

    assign {b_ctrl, b_col, b_pix} = pop_data;

    bbe_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_ctrl      (b_ctrl),
        .q_col       (b_col),
        .q_pix       (b_pix),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_frame_end (m_frame_end)
    );

endmodule

`default_nettype wire
